@@ src/control_surface_input_scanner_core_macros.svh @@
// Assertion macros shared by the control surface input scanner RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CONTROL_SURFACE_INPUT_SCANNER_CORE_MACROS_SVH
`define CONTROL_SURFACE_INPUT_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CSIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CSIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/csis_pkg.sv @@
// Shared types and constants of the control surface input scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package csis_pkg;

  // Default configuration of the block.
  localparam int ADC_BITS_DEF      = 10;
  localparam int ENCODER_COUNT_DEF = 4;
  localparam int JOY_CHANNELS_DEF  = 3;

  // Report channels: fader, four encoders, three joystick axes.
  localparam int NUM_CH   = 8;
  localparam int CH_W     = 3;
  localparam int ENC_CH0  = 1;
  localparam int JOY_CH0  = 5;

  // Fader window and scale, 0.9445 in unsigned Q0.20.
  localparam int          FADER_K_W   = 9;
  localparam int          FADER_SCALE_W = 20;
  localparam int          FADER_PROD_W  = FADER_K_W + FADER_SCALE_W;
  localparam int unsigned FADER_LOW   = 394;
  localparam int unsigned FADER_HIGH  = 664;
  localparam logic [FADER_SCALE_W-1:0] FADER_SCALE = 20'd990380;

  // Packet constants.
  localparam logic [7:0] CMD_ADC    = 8'd38;
  localparam logic [7:0] PKT_B_BASE = 8'd64;
  localparam logic [7:0] PKT_C_BASE = 8'd128;

  // Encoder phase and report codes.
  localparam logic [1:0] PHASE_DETENT = 2'd3;
  localparam logic [7:0] ENC_UP       = 8'd1;
  localparam logic [7:0] ENC_DOWN     = 8'd255;

  // Configuration register indexes.
  localparam int          CFG_IDX_W = 2;
  localparam logic [1:0]  REG_JOY_X = 2'd0;
  localparam logic [1:0]  REG_JOY_Y = 2'd1;
  localparam logic [1:0]  REG_JOY_Z = 2'd2;
  localparam logic [7:0]  JOY_SHIFT_RESET = 8'd128;

  // What one lane found for the current scan.
  typedef struct packed {
    logic       hit;
    logic [7:0] data;
  } csis_rpt_t;

endpackage

@@ src/csis_fader_lane.sv @@
// Fader lane: clamps and scales the fader sample and flags a position change.
// Depends on csis_pkg.
`timescale 1ns / 1ps
module csis_fader_lane #(
  parameter int ADC_BITS = csis_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [ADC_BITS-1:0] sample,
  output csis_pkg::csis_rpt_t rpt
);
  import csis_pkg::*;

  logic [FADER_K_W-1:0]    k;
  logic [FADER_PROD_W-1:0] prod;
  logic [7:0]              pos;
  logic [7:0]              position;

  // Clamp into the active window and remove the offset.
  always_comb begin
    if (sample < ADC_BITS'(FADER_LOW)) begin
      k = '0;
    end else if (sample > ADC_BITS'(FADER_HIGH)) begin
      k = FADER_K_W'(FADER_HIGH - FADER_LOW);
    end else begin
      k = FADER_K_W'(sample - ADC_BITS'(FADER_LOW));
    end
  end

  // Fixed-point scale; the position is the integer part.
  assign prod = FADER_PROD_W'(k) * FADER_PROD_W'(FADER_SCALE);
  assign pos  = prod[FADER_SCALE_W+7:FADER_SCALE_W];

  assign rpt.hit  = (pos != position);
  assign rpt.data = pos;

  // Last reported position.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (take && rpt.hit) begin
      position <= pos;
    end
  end

endmodule

@@ src/csis_enc_lane.sv @@
// Encoder lane: tracks one quadrature encoder and reports a step at detent.
// Depends on csis_pkg.
`timescale 1ns / 1ps
module csis_enc_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [1:0]          pins,
  output csis_pkg::csis_rpt_t rpt
);
  import csis_pkg::*;

  localparam logic [1:0] FWD_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  logic [1:0] phase;
  logic       moved;
  logic       up;
  logic       down;

  // Forward runs 0,1,3,2; the reverse counts down.
  assign moved = (pins != phase);
  assign up    = (FWD_NEXT[phase] == pins);
  assign down  = (FWD_NEXT[pins] == phase);

  assign rpt.hit  = moved && (pins == PHASE_DETENT) && (up || down);
  assign rpt.data = up ? ENC_UP : ENC_DOWN;

  // Phase follows the pins on every change taken with a scan beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_DETENT;
    end else if (take && moved) begin
      phase <= pins;
    end
  end

endmodule

@@ src/csis_joy_lane.sv @@
// Joystick lane: centers and scales one axis and flags a nonzero change.
// Depends on csis_pkg.
`timescale 1ns / 1ps
module csis_joy_lane #(
  parameter int ADC_BITS = csis_pkg::ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [ADC_BITS-1:0] sample,
  input  logic [7:0]          shift,
  output csis_pkg::csis_rpt_t rpt
);
  import csis_pkg::*;

  localparam int QW = ADC_BITS - 2;
  localparam int DW = ADC_BITS - 1;
  localparam int VW = ADC_BITS - 4;

  logic [QW-1:0]        q;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] adj;
  logic signed [VW-1:0] v;
  logic signed [VW-1:0] last_v;

  // Quarter the sample and remove the center offset.
  assign q    = sample[ADC_BITS-1:2];
  assign diff = signed'(DW'(q)) - signed'(DW'(shift));

  // Divide by eight, rounding toward zero.
  assign adj = diff + (diff[DW-1] ? DW'(7) : DW'(0));
  assign v   = adj[DW-1:3];

  assign rpt.hit  = (v != '0) && (v != last_v);
  assign rpt.data = 8'(v);

  // Last reported value; zero readings leave it alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_v <= '0;
    end else if (take && rpt.hit) begin
      last_v <= v;
    end
  end

endmodule

@@ src/csis_merge.sv @@
// Merge stage: holds the lane reports of one scan and sends them in channel
// order as three-byte packets. Depends on csis_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "control_surface_input_scanner_core_macros.svh"
module csis_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  csis_pkg::csis_rpt_t rpt [csis_pkg::NUM_CH],
  output logic                load_ok,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // first_byte, second_byte, third_byte
  output logic                m_tlast
);
  import csis_pkg::*;

  logic [NUM_CH-1:0] pend;
  logic [7:0]        data [NUM_CH];
  logic [CH_W-1:0]   sel;
  logic [NUM_CH-1:0] rest;
  logic              sent;
  logic [7:0]        d;

  // Lowest pending channel goes first.
  always_comb begin
    sel = '0;
    for (int i = NUM_CH - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = CH_W'(i);
      end
    end
  end

  always_comb begin
    rest      = pend;
    rest[sel] = 1'b0;
  end

  assign sent     = m_tvalid && m_tready;
  assign m_tvalid = |pend;
  assign m_tlast  = (rest == '0);
  assign load_ok  = (pend == '0) || (sent && m_tlast);

  // Packet formatting of the selected report.
  assign d = data[sel];
  assign m_tdata[7:0]   = CMD_ADC;
  assign m_tdata[15:8]  = PKT_B_BASE + {3'b000, sel, d[7:6]};
  assign m_tdata[23:16] = PKT_C_BASE + {2'b00, d[5:0]};

  // Report bank: loaded per scan, drained one beat at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        pend[i] <= rpt[i].hit;
      end
    end else if (sent) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        data[i] <= rpt[i].data;
      end
    end
  end

  `CSIS_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, $stable(pend) && $stable(sel), "stalled packet changed")
  `CSIS_ASSERT_NOW(a_last_single, m_tvalid && m_tlast, $countones(pend) == 1, "last flag with several packets pending")
  `CSIS_ASSERT_NOW(a_load_drained, load, ($countones(pend) == 0) || (($countones(pend) == 1) && m_tready), "scan loaded over pending packets")

endmodule

@@ src/control_surface_input_scanner_core.sv @@
// Control surface input scanner: a new scan beat is taken in the same cycle that the
// previous scan's last packet leaves (or at once when nothing is pending), and its
// packets follow from the next cycle, one per beat while m_tready is high, so a scan
// is not taken until the report bank in the merge stage has sent all of the last one.
// A fader lane, four encoder lanes and three joystick lanes decode each scan in
// parallel, and the merge stage sends their reports as 38 / channel / data
// packets in channel order, tlast marking the scan's final packet.
// Depends on csis_pkg and the lane and merge modules.
`timescale 1ns / 1ps
module control_surface_input_scanner_core #(
  parameter int ADC_BITS      = csis_pkg::ADC_BITS_DEF,
  parameter int ENCODER_COUNT = csis_pkg::ENCODER_COUNT_DEF,
  parameter int JOY_CHANNELS  = csis_pkg::JOY_CHANNELS_DEF,
  localparam int S_TDATA_W    = ((4 * ADC_BITS + 8 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // fader_sample, encoder_pins, joy_x, joy_y, joy_z
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,  // first_byte, second_byte, third_byte
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [csis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);
  import csis_pkg::*;

  logic                take;
  logic                load_ok;
  logic [7:0]          joy_shift [3];
  logic [ADC_BITS-1:0] joy_sample [3];
  csis_rpt_t           rpt [NUM_CH];

  assign s_tready  = load_ok;
  assign take      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      joy_shift[0] <= JOY_SHIFT_RESET;
      joy_shift[1] <= JOY_SHIFT_RESET;
      joy_shift[2] <= JOY_SHIFT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_JOY_X: joy_shift[0] <= cfg_data;
        REG_JOY_Y: joy_shift[1] <= cfg_data;
        REG_JOY_Z: joy_shift[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fader lane.
  csis_fader_lane #(.ADC_BITS(ADC_BITS)) u_fader (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .sample (s_tdata[ADC_BITS-1:0]),
    .rpt    (rpt[0])
  );

  // Encoder lanes.
  for (genvar p = 0; p < 4; p++) begin : g_enc
    if (p < ENCODER_COUNT) begin : g_on
      csis_enc_lane u_enc (
        .clk  (clk),
        .rst  (rst),
        .take (take),
        .pins (s_tdata[ADC_BITS+2*p+1 -: 2]),
        .rpt  (rpt[ENC_CH0+p])
      );
    end else begin : g_off
      assign rpt[ENC_CH0+p] = '0;
    end
  end

  // Joystick lanes.
  for (genvar j = 0; j < 3; j++) begin : g_joy
    assign joy_sample[j] = s_tdata[ADC_BITS*(j+2)+7 -: ADC_BITS];
    if (j < JOY_CHANNELS) begin : g_on
      csis_joy_lane #(.ADC_BITS(ADC_BITS)) u_joy (
        .clk    (clk),
        .rst    (rst),
        .take   (take),
        .sample (joy_sample[j]),
        .shift  (joy_shift[j]),
        .rpt    (rpt[JOY_CH0+j])
      );
    end else begin : g_off
      assign rpt[JOY_CH0+j] = '0;
    end
  end

  // Merge stage and output beat.
  csis_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .rpt      (rpt),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
